### rtl/rbd_pkg.sv
// ---------------------------------------------------------------------------
// rbd_pkg
// Shared constants, types and channel arithmetic for the 2x2 RGBA box
// downsampler.
// ---------------------------------------------------------------------------
package rbd_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int CHANNELS    = 4;
    localparam int LINE_DEPTH  = MAX_WIDTH / 2;
    localparam int ADDR_W      = $clog2(LINE_DEPTH);
    localparam int DIM_W       = 13;
    localparam int DEST_W      = 12;
    localparam int PIX_W       = 32;
    localparam int CH_SUM_W    = 9;
    localparam int SUM_W       = 4 * CH_SUM_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    // Register indexes, taken from paddr[2].
    localparam logic REG_SRC_WIDTH  = 1'b0;
    localparam logic REG_SRC_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,  // store a pair sum of an even row
        OP_SELF  = 2'd1,  // single-row source: average the pair sum with itself
        OP_PAIR  = 2'd2   // odd row: average with the stored pair sum above
    } t_op_kind;

    typedef struct packed {
        t_op_kind              kind;
        logic [ADDR_W-1:0]     addr;
        logic [SUM_W-1:0]      hs;
        logic                  last;
        logic [DEST_W-1:0]     dest_width;
        logic [DEST_W-1:0]     dest_height;
    } t_op;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic             restart;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Per-channel 9-bit sums of two pixels; channels at or above CHANNELS are zero.
    function automatic logic [SUM_W-1:0] pair_sum(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        logic [SUM_W-1:0] r;
        r = '0;
        for (int c = 0; c < CHANNELS && c < 4; c++) begin
            r[CH_SUM_W*c +: CH_SUM_W] = {1'b0, a[8*c +: 8]} + {1'b0, b[8*c +: 8]};
        end
        return r;
    endfunction

    // Rounded average of two pair sums, one byte per channel.
    function automatic logic [PIX_W-1:0] average(input logic [SUM_W-1:0] t,
                                                 input logic [SUM_W-1:0] b);
        logic [PIX_W-1:0] r;
        logic [9:0]       s;
        r = '0;
        for (int c = 0; c < CHANNELS && c < 4; c++) begin
            s = {1'b0, t[CH_SUM_W*c +: CH_SUM_W]} + {1'b0, b[CH_SUM_W*c +: CH_SUM_W]}
                + 10'd2;
            r[8*c +: 8] = s[9:2];
        end
        return r;
    endfunction

endpackage

### rtl/rbd_pix_if.sv
// ---------------------------------------------------------------------------
// rbd_pix_if
// Source pixel stream: valid/ready handshake carrying one RGBA8 pixel.
// ---------------------------------------------------------------------------
interface rbd_pix_if;
    logic                      valid;
    logic                      ready;
    logic [rbd_pkg::PIX_W-1:0] in_pixel;

    modport source (output valid, output in_pixel, input ready);
    modport sink   (input valid, input in_pixel, output ready);
endinterface

### rtl/rbd_res_if.sv
// ---------------------------------------------------------------------------
// rbd_res_if
// Result stream: valid/ready handshake carrying one averaged pixel and the
// size of the output level.
// ---------------------------------------------------------------------------
interface rbd_res_if;
    logic                       valid;
    logic                       ready;
    logic [rbd_pkg::PIX_W-1:0]  out_pixel;
    logic                       last_of_level;
    logic [rbd_pkg::DEST_W-1:0] dest_width;
    logic [rbd_pkg::DEST_W-1:0] dest_height;

    modport source (output valid, output out_pixel, output last_of_level,
                    output dest_width, output dest_height, input ready);
    modport sink   (input valid, input out_pixel, input last_of_level,
                    input dest_width, input dest_height, output ready);
endinterface

### rtl/rbd_ram.sv
// ---------------------------------------------------------------------------
// rbd_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ---------------------------------------------------------------------------
module rbd_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/rbd_front.sv
// ---------------------------------------------------------------------------
// rbd_front
// Accepts source pixels, tracks the raster position, forms horizontal pair
// sums and classifies each pixel into a line-store operation.
// ---------------------------------------------------------------------------
module rbd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rbd_pkg::t_cfg i_cfg,
    rbd_pix_if.sink       i_pix,
    input  logic          i_q_full,
    output logic          o_push,
    output rbd_pkg::t_op  o_op
);
    logic [rbd_pkg::DIM_W-1:0]  r_col, n_col;
    logic [rbd_pkg::DIM_W-1:0]  r_row, n_row;
    logic [rbd_pkg::PIX_W-1:0]  r_held, n_held;

    logic [rbd_pkg::DIM_W-1:0]  w_eff, h_eff, col, row;
    logic [rbd_pkg::DEST_W-1:0] dw, dh, y;
    logic [rbd_pkg::ADDR_W-1:0] x;
    logic                       accept, have;
    logic [rbd_pkg::SUM_W-1:0]  hs;

    assign i_pix.ready = !i_q_full;
    assign accept      = i_pix.valid && !i_q_full;

    always_comb begin
        // Effective sizes: zero acts as one, width clamps to the line store.
        w_eff = i_cfg.width;
        if (i_cfg.width == '0) begin
            w_eff = rbd_pkg::DIM_W'(1);
        end else if (32'(i_cfg.width) > 32'(rbd_pkg::MAX_WIDTH)) begin
            w_eff = rbd_pkg::DIM_W'(rbd_pkg::MAX_WIDTH);
        end
        h_eff = (i_cfg.height == '0) ? rbd_pkg::DIM_W'(1) : i_cfg.height;
        dw    = (w_eff[rbd_pkg::DIM_W-1:1] == '0) ? rbd_pkg::DEST_W'(1)
                                                  : w_eff[rbd_pkg::DIM_W-1:1];
        dh    = (h_eff[rbd_pkg::DIM_W-1:1] == '0) ? rbd_pkg::DEST_W'(1)
                                                  : h_eff[rbd_pkg::DIM_W-1:1];
        col   = (r_col < w_eff) ? r_col : '0;
        row   = (r_row < h_eff) ? r_row : '0;

        have   = 1'b0;
        hs     = '0;
        x      = '0;
        n_held = r_held;
        if (w_eff == rbd_pkg::DIM_W'(1)) begin
            hs   = rbd_pkg::pair_sum(i_pix.in_pixel, i_pix.in_pixel);
            have = 1'b1;
        end else if (!col[0]) begin
            n_held = i_pix.in_pixel;
        end else if (col < {dw, 1'b0}) begin
            hs   = rbd_pkg::pair_sum(r_held, i_pix.in_pixel);
            have = 1'b1;
            x    = col[rbd_pkg::ADDR_W:1];
        end

        y       = '0;
        o_op    = '0;
        o_push  = 1'b0;
        if (have) begin
            if (h_eff == rbd_pkg::DIM_W'(1)) begin
                o_op.kind = rbd_pkg::OP_SELF;
                o_push    = accept;
            end else if (row < {dh, 1'b0}) begin
                if (!row[0]) begin
                    o_op.kind = rbd_pkg::OP_WRITE;
                end else begin
                    o_op.kind = rbd_pkg::OP_PAIR;
                    y         = row[rbd_pkg::DIM_W-1:1];
                end
                o_push = accept;
            end
        end
        o_op.addr        = x;
        o_op.hs          = hs;
        o_op.last        = ({1'b0, x} == dw - 1'b1) && (y == dh - 1'b1);
        o_op.dest_width  = dw;
        o_op.dest_height = dh;

        // Advance the raster position; wrap starts a new level of the same size.
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            n_col = col + 1'b1;
            n_row = row;
            if (n_col >= w_eff) begin
                n_col = '0;
                n_row = row + 1'b1;
                if (n_row >= h_eff) begin
                    n_row = '0;
                end
            end
        end
        if (i_cfg.restart) begin
            n_col = '0;
            n_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_held <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (accept) begin
                r_held <= n_held;
            end
        end
    end
endmodule

### rtl/rbd_queue.sv
// ---------------------------------------------------------------------------
// rbd_queue
// Short FIFO of line-store operations between the front and back parts.
// ---------------------------------------------------------------------------
module rbd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rbd_pkg::t_op     i_op,
    input  logic             i_pop,
    output rbd_pkg::t_op     o_head,
    output rbd_pkg::t_q_stat o_stat
);
    rbd_pkg::t_op               r_buf [rbd_pkg::QUEUE_DEPTH];
    logic [rbd_pkg::QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [rbd_pkg::QCNT_W-1:0] r_count, n_count;
    logic                       do_push, do_pop;

    assign o_stat.full  = (r_count == rbd_pkg::QCNT_W'(rbd_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_buf[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end
endmodule

### rtl/rbd_back.sv
// ---------------------------------------------------------------------------
// rbd_back
// Executes line-store operations: writes even-row pair sums, reads them back
// for odd rows, averages and holds the result in an output register.
// ---------------------------------------------------------------------------
module rbd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rbd_pkg::t_op     i_op,
    input  rbd_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    rbd_res_if.source        o_res
);
    logic                      r_b_valid;
    rbd_pkg::t_op              r_b_op;
    logic                      r_o_valid;
    logic [rbd_pkg::PIX_W-1:0] r_o_pixel;
    logic                      r_o_last;
    logic [rbd_pkg::DEST_W-1:0] r_o_dw, r_o_dh;

    logic                      b_adv, b_free, ram_we, ram_re;
    logic [rbd_pkg::SUM_W-1:0] ram_rdata, top_sum;

    // Stage B drains into the output register when it is empty or being taken.
    assign b_adv  = r_b_valid && (!r_o_valid || o_res.ready);
    assign b_free = !r_b_valid || b_adv;
    assign o_pop  = !i_q_stat.empty && b_free;
    assign ram_we = o_pop && (i_op.kind == rbd_pkg::OP_WRITE);
    assign ram_re = o_pop && (i_op.kind == rbd_pkg::OP_PAIR);

    rbd_ram #(
        .WIDTH (rbd_pkg::SUM_W),
        .DEPTH (rbd_pkg::LINE_DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_op.addr),
        .i_wdata (i_op.hs),
        .i_re    (ram_re),
        .i_raddr (i_op.addr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        case (r_b_op.kind)
            rbd_pkg::OP_PAIR: top_sum = ram_rdata;
            default:          top_sum = r_b_op.hs;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b_op <= i_op;
        end
        if (b_adv) begin
            r_o_pixel <= rbd_pkg::average(top_sum, r_b_op.hs);
            r_o_last  <= r_b_op.last;
            r_o_dw    <= r_b_op.dest_width;
            r_o_dh    <= r_b_op.dest_height;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (b_free) begin
                r_b_valid <= o_pop && (i_op.kind != rbd_pkg::OP_WRITE);
            end
            if (b_adv) begin
                r_o_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid         = r_o_valid;
    assign o_res.out_pixel     = r_o_pixel;
    assign o_res.last_of_level = r_o_last;
    assign o_res.dest_width    = r_o_dw;
    assign o_res.dest_height   = r_o_dh;
endmodule

### rtl/rgba_box_downsample_2x2.sv
// ---------------------------------------------------------------------------
// rgba_box_downsample_2x2
// One mip level of an RGBA8 image by 2x2 box averaging, streamed in raster
// order.
// ---------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Carries
// -------   ---------  -------------------  ---------------------------------
// i_pix     in         valid/ready          in_pixel (R,G,B,A from byte 0 up)
// o_res     out        valid/ready          out_pixel, last_of_level,
//                                           dest_width, dest_height
// APB       in         psel/penable/pready  src_width at 0x0, src_height at 0x4
//
// The block takes one pixel per clock while the queue has room. The odd-row
// pixel completing a 2x2 block is written into the queue as an operation;
// the back pops it into stage B and reads the line store, and then loads
// the output register. A stalled output can hold it at either step.
// The line store has one write and one read port and is used by at most one
// operation per cycle, which sets the one-pixel-per-clock rate.
// Reset is synchronous and active low; it clears the raster position, the
// queue and the valid flags. The line store is not cleared: every entry is
// written in an even row before the odd row below reads it.
// A stalled output fills the four-entry queue, after which i_pix.ready drops.
//
// Front: rbd_front tracks the position, forms horizontal pair sums and
// classifies each pixel (store pair sum, average with the stored sum, average
// a single row with itself, or nothing for a held or dropped pixel).
// Back: rbd_back performs those operations on the line store and drives the
// output register.
// ---------------------------------------------------------------------------
module rgba_box_downsample_2x2 (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    rbd_pix_if.sink                     i_pix,
    rbd_res_if.source                   o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rbd_pkg::PADDR_W-1:0] paddr,
    input  logic [rbd_pkg::PDATA_W-1:0] pwdata,
    output logic [rbd_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    logic [rbd_pkg::DIM_W-1:0] r_src_width;
    logic [rbd_pkg::DIM_W-1:0] r_src_height;
    logic                      cfg_wr;
    rbd_pkg::t_cfg             cfg;
    rbd_pkg::t_op              push_op, head_op;
    rbd_pkg::t_q_stat          q_stat;
    logic                      q_push, q_pop;

    // Configuration port. Every write completes in its access cycle.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= rbd_pkg::DIM_W'(1);
            r_src_height <= rbd_pkg::DIM_W'(1);
        end else if (cfg_wr) begin
            case (paddr[2])
                rbd_pkg::REG_SRC_WIDTH:  r_src_width  <= pwdata[rbd_pkg::DIM_W-1:0];
                rbd_pkg::REG_SRC_HEIGHT: r_src_height <= pwdata[rbd_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            rbd_pkg::REG_SRC_WIDTH:
                prdata = rbd_pkg::PDATA_W'(r_src_width);
            default:
                prdata = rbd_pkg::PDATA_W'(r_src_height);
        endcase
    end

    // Any register write restarts the level at the top-left pixel.
    assign cfg.width   = r_src_width;
    assign cfg.height  = r_src_height;
    assign cfg.restart = cfg_wr;

    rbd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_pix    (i_pix),
        .i_q_full (q_stat.full),
        .o_push   (q_push),
        .o_op     (push_op)
    );

    rbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (push_op),
        .i_pop   (q_pop),
        .o_head  (head_op),
        .o_stat  (q_stat)
    );

    rbd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (head_op),
        .i_q_stat (q_stat),
        .o_pop    (q_pop),
        .o_res    (o_res)
    );

    // The front never hands an operation to a full queue.
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("operation pushed into a full queue");

    // The back never takes an operation from an empty queue.
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("operation popped from an empty queue");

    // A delivered result always carries a nonzero level size.
    a_dest_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.dest_width != '0) && (o_res.dest_height != '0))
        else $error("result with zero level size");
endmodule

### sim/rgba_box_downsample_2x2_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgba_box_downsample_2x2_tb
// Self-checking bench for the 2x2 RGBA box downsampler. Source levels of
// many sizes stream through the pixel channel while the result channel
// stalls at random; a scoreboard predicts every averaged pixel and compares
// it field by field. The size registers are written and read back over APB
// between levels.
// ---------------------------------------------------------------------------
module rgba_box_downsample_2x2_tb;

    // Cycles without any transfer before the run is declared hung. The
    // slowest legal gap is a sender pause plus a result stall and the
    // pipeline, so this leaves a wide margin.
    localparam int IDLE_LIMIT    = 2000;
    // Pause before a register write, after the last expected result, so that
    // store-only operations still in the queue have left the back end.
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 1000;
    // The last stretch of random pixels runs with no gaps and no stalls.
    localparam int CALM_ITEMS    = 150;

    typedef struct {
        logic [rbd_pkg::PIX_W-1:0]  pixel;
        logic                       last;
        logic [rbd_pkg::DEST_W-1:0] dest_width;
        logic [rbd_pkg::DEST_W-1:0] dest_height;
    } t_mip_texel;

    // Predicts the output level from the accepted source pixels and checks
    // each result against the oldest prediction.
    class mip_scoreboard;
        logic [rbd_pkg::DIM_W-1:0] width_reg;
        logic [rbd_pkg::DIM_W-1:0] height_reg;
        logic [rbd_pkg::SUM_W-1:0] upper_pair_sums [rbd_pkg::LINE_DEPTH];
        logic [rbd_pkg::PIX_W-1:0] left_pixel;
        int unsigned               next_col;
        int unsigned               next_row;
        t_mip_texel                expected_texels [$];
        int                        failures;

        function new();
            width_reg  = 1;
            height_reg = 1;
            left_pixel = '0;
            next_col   = 0;
            next_row   = 0;
            failures   = 0;
            foreach (upper_pair_sums[i]) upper_pair_sums[i] = '0;
        endfunction

        function int unsigned level_width();
            if (width_reg == 0) return 1;
            if (width_reg > rbd_pkg::MAX_WIDTH) return rbd_pkg::MAX_WIDTH;
            return width_reg;
        endfunction

        function int unsigned level_height();
            return (height_reg == 0) ? 1 : height_reg;
        endfunction

        function int unsigned pixels_per_level();
            return level_width() * level_height();
        endfunction

        function logic [rbd_pkg::DIM_W-1:0] register_value(logic idx);
            return (idx == rbd_pkg::REG_SRC_WIDTH) ? width_reg : height_reg;
        endfunction

        // Any write restarts the level at the top-left pixel.
        function void write_register(logic idx, logic [rbd_pkg::PDATA_W-1:0] value);
            if (idx == rbd_pkg::REG_SRC_WIDTH) begin
                width_reg = value[rbd_pkg::DIM_W-1:0];
            end else begin
                height_reg = value[rbd_pkg::DIM_W-1:0];
            end
            next_col = 0;
            next_row = 0;
        endfunction

        function logic [rbd_pkg::SUM_W-1:0] add_pair(logic [rbd_pkg::PIX_W-1:0] a,
                                                     logic [rbd_pkg::PIX_W-1:0] b);
            logic [rbd_pkg::SUM_W-1:0] r;
            r = '0;
            for (int c = 0; c < rbd_pkg::CHANNELS && c < 4; c++) begin
                r[rbd_pkg::CH_SUM_W*c +: rbd_pkg::CH_SUM_W] =
                    rbd_pkg::CH_SUM_W'(a[8*c +: 8]) + rbd_pkg::CH_SUM_W'(b[8*c +: 8]);
            end
            return r;
        endfunction

        function logic [rbd_pkg::PIX_W-1:0] blend_pairs(logic [rbd_pkg::SUM_W-1:0] upper,
                                                        logic [rbd_pkg::SUM_W-1:0] lower);
            logic [rbd_pkg::PIX_W-1:0] r;
            int unsigned               s;
            r = '0;
            for (int c = 0; c < rbd_pkg::CHANNELS && c < 4; c++) begin
                s = upper[rbd_pkg::CH_SUM_W*c +: rbd_pkg::CH_SUM_W]
                    + lower[rbd_pkg::CH_SUM_W*c +: rbd_pkg::CH_SUM_W] + 2;
                r[8*c +: 8] = 8'(s >> 2);
            end
            return r;
        endfunction

        function void note_pixel(logic [rbd_pkg::PIX_W-1:0] px);
            int unsigned               w, h, dw, dh, col, row, x, y;
            logic [rbd_pkg::SUM_W-1:0] hs;
            bit                        have, emit;
            t_mip_texel                t;
            w    = level_width();
            h    = level_height();
            dw   = (w / 2 != 0) ? w / 2 : 1;
            dh   = (h / 2 != 0) ? h / 2 : 1;
            col  = (next_col < w) ? next_col : 0;
            row  = (next_row < h) ? next_row : 0;
            have = 0;
            emit = 0;
            x    = 0;
            y    = 0;
            hs   = '0;
            if (w == 1) begin
                hs   = add_pair(px, px);
                have = 1;
            end else if (col % 2 == 0) begin
                left_pixel = px;
            end else if (col < 2 * dw) begin
                hs   = add_pair(left_pixel, px);
                have = 1;
                x    = col / 2;
            end
            if (have) begin
                if (h == 1) begin
                    t.pixel = blend_pairs(hs, hs);
                    emit    = 1;
                end else if (row < 2 * dh) begin
                    if (row % 2 == 0) begin
                        upper_pair_sums[x] = hs;
                    end else begin
                        t.pixel = blend_pairs(upper_pair_sums[x], hs);
                        emit    = 1;
                        y       = row / 2;
                    end
                end
            end
            col++;
            if (col >= w) begin
                col = 0;
                row++;
                if (row >= h) row = 0;
            end
            next_col = col;
            next_row = row;
            if (emit) begin
                t.last        = (x == dw - 1) && (y == dh - 1);
                t.dest_width  = rbd_pkg::DEST_W'(dw);
                t.dest_height = rbd_pkg::DEST_W'(dh);
                expected_texels.insert(expected_texels.size(), t);
            end
        endfunction

        function void check_result(logic [rbd_pkg::PIX_W-1:0] pixel, logic last,
                                   logic [rbd_pkg::DEST_W-1:0] dest_w,
                                   logic [rbd_pkg::DEST_W-1:0] dest_h);
            t_mip_texel t;
            if (expected_texels.size() == 0) begin
                $error("unexpected result: out_pixel %h", pixel);
                failures++;
                return;
            end
            t = expected_texels.pop_front();
            if (pixel !== t.pixel) begin
                $error("out_pixel: expected %h, actual %h", t.pixel, pixel);
                failures++;
            end
            if (last !== t.last) begin
                $error("last_of_level: expected %b, actual %b", t.last, last);
                failures++;
            end
            if (dest_w !== t.dest_width) begin
                $error("dest_width: expected %0d, actual %0d", t.dest_width, dest_w);
                failures++;
            end
            if (dest_h !== t.dest_height) begin
                $error("dest_height: expected %0d, actual %0d", t.dest_height, dest_h);
                failures++;
            end
        endfunction
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [rbd_pkg::PADDR_W-1:0] paddr;
    logic [rbd_pkg::PDATA_W-1:0] pwdata;
    logic [rbd_pkg::PDATA_W-1:0] prdata;
    logic                        pready;

    rbd_pix_if pix_if ();
    rbd_res_if res_if ();

    mip_scoreboard sb;
    bit            quiet_tail  = 1'b0;  // no gaps and no stalls in the final stretch
    bit            gappy       = 1'b1;  // sender may pause during this level
    int            ready_run   = 0;
    int            idle_cycles = 0;

    rgba_box_downsample_2x2 u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // The result side switches at random between runs of ready and stall
    // bursts. Long ready runs give stretches with no stalls at all.
    always @(negedge i_clk) begin
        if (ready_run == 0) begin
            if (quiet_tail || $urandom_range(0, 3) != 0) begin
                res_if.ready <= 1'b1;
                ready_run    <= $urandom_range(1, 40);
            end else begin
                res_if.ready <= 1'b0;
                ready_run    <= $urandom_range(1, 15);
            end
        end else begin
            ready_run <= ready_run - 1;
        end
    end

    // Every result transfer is checked at the clock edge that completes it.
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            sb.check_result(res_if.out_pixel, res_if.last_of_level,
                            res_if.dest_width, res_if.dest_height);
        end
    end

    // The watchdog restarts on any transfer on either stream or on APB; a
    // long silence means the block hung or a result never came.
    always @(posedge i_clk) begin
        if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)
                || (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("rgba_box_downsample_2x2_tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Bytes are biased toward 0x00 and 0xFF so that the rounding and the
    // carry into the ninth bit of each pair sum are exercised often.
    function automatic logic [rbd_pkg::PIX_W-1:0] random_pixel();
        logic [rbd_pkg::PIX_W-1:0] px;
        for (int c = 0; c < 4; c++) begin
            case ($urandom_range(0, 5))
                0:       px[8*c +: 8] = 8'h00;
                1:       px[8*c +: 8] = 8'hFF;
                default: px[8*c +: 8] = 8'($urandom);
            endcase
        end
        return px;
    endfunction

    // A random register word. The low 13 bits give the size; now and then
    // the upper bits carry junk that the register must discard.
    function automatic logic [rbd_pkg::PDATA_W-1:0] random_dimension(int unsigned cap);
        logic [rbd_pkg::PDATA_W-1:0] word;
        case ($urandom_range(0, 9))
            0:       word = 1;
            1:       word = 2;
            2:       word = 0;  // a zero size behaves as one
            3:       word = $urandom_range(2, cap);
            default: word = $urandom_range(2, 8);
        endcase
        if ($urandom_range(0, 4) == 0) word = word | ($urandom & 32'hFFFF_E000);
        return word;
    endfunction

    // Called at a falling edge; returns at the falling edge after the
    // transfer. Valid is left high so the next pixel can follow at once.
    task automatic send_pixel(input logic [rbd_pkg::PIX_W-1:0] px);
        int gap;
        if (gappy && !quiet_tail && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            pix_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix_if.valid    <= 1'b1;
        pix_if.in_pixel <= px;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        sb.note_pixel(px);
        @(negedge i_clk);
    endtask

    task automatic send_pixels(input int unsigned count);
        repeat (count) send_pixel(random_pixel());
    endtask

    // Stops the source and waits until every predicted result has arrived,
    // then lets pipeline work that yields no result finish.
    task automatic drain();
        pix_if.valid <= 1'b0;
        while (sb.expected_texels.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One APB transfer: setup, then access until pready. The bus is left
    // selected so that transfers can run back to back; apb_release ends it.
    task automatic apb_access(input logic idx, input bit is_write,
                              input logic [rbd_pkg::PDATA_W-1:0] wdata,
                              output logic [rbd_pkg::PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= rbd_pkg::PADDR_W'({idx, 2'b00});
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        if (is_write) sb.write_register(idx, wdata);
        @(negedge i_clk);
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic verify_register(input logic idx);
        logic [rbd_pkg::PDATA_W-1:0] rd;
        apb_access(idx, 1'b0, '0, rd);
        if (rd !== rbd_pkg::PDATA_W'(sb.register_value(idx))) begin
            $error("%s: expected %h, actual %h",
                   (idx == rbd_pkg::REG_SRC_WIDTH) ? "src_width" : "src_height",
                   rbd_pkg::PDATA_W'(sb.register_value(idx)), rd);
            sb.failures++;
        end
    endtask

    task automatic write_and_verify(input logic idx,
                                    input logic [rbd_pkg::PDATA_W-1:0] value);
        logic [rbd_pkg::PDATA_W-1:0] rd;
        apb_access(idx, 1'b1, value, rd);
        verify_register(idx);
    endtask

    task automatic reprogram(input logic [rbd_pkg::PDATA_W-1:0] w_word,
                             input logic [rbd_pkg::PDATA_W-1:0] h_word);
        drain();
        write_and_verify(rbd_pkg::REG_SRC_WIDTH, w_word);
        write_and_verify(rbd_pkg::REG_SRC_HEIGHT, h_word);
        apb_release();
    endtask

    task automatic reprogram_one(input logic idx, input logic [rbd_pkg::PDATA_W-1:0] value);
        drain();
        write_and_verify(idx, value);
        apb_release();
    endtask

    initial begin
        int unsigned                 random_items;
        int unsigned                 per_level;
        int unsigned                 count;
        logic [rbd_pkg::PDATA_W-1:0] w_word;
        logic [rbd_pkg::PDATA_W-1:0] h_word;

        sb              = new();
        pix_if.valid    = 1'b0;
        pix_if.in_pixel = '0;
        res_if.ready    = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        i_rst_n         = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Out of reset the level is 1x1: each pixel comes back unchanged
        // and closes its own level.
        verify_register(rbd_pkg::REG_SRC_WIDTH);
        verify_register(rbd_pkg::REG_SRC_HEIGHT);
        apb_release();
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);

        // Two 2x2 levels back to back; the second starts when the counters
        // wrap. Its bytes sum to 4, 3, 2 and 1, which probes the rounding.
        reprogram(32'd2, 32'd2);
        repeat (4) send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0000_0001);
        send_pixel(32'h0000_0101);
        send_pixel(32'h0001_0101);
        send_pixel(32'h0101_0101);

        // Zero sizes with junk in the upper bits of the written word.
        reprogram(32'hFFFF_E000, 32'h8000_0000);
        send_pixels(2);

        // Odd 3x3: the last column and the last row are dropped.
        reprogram(32'd3, 32'd3);
        send_pixels(9);

        // A single column pairs each pixel with itself, a single row pairs
        // each row with itself.
        reprogram(32'd1, 32'd2);
        send_pixels(2);
        reprogram(32'd2, 32'd1);
        send_pixels(2);

        // Extreme sizes. A width above the maximum is clamped, which shows
        // in the reported level width. A very tall level is cut short by the
        // next register write.
        reprogram(32'd8191, 32'd1);
        send_pixels(60);
        reprogram(32'd1, 32'd4096);
        send_pixels(60);
        reprogram(32'd2, 32'd8191);
        send_pixels(60);

        // Random levels: mostly whole levels, sometimes several in a row,
        // and now and then one broken off by a register write.
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            quiet_tail = (random_items >= RANDOM_ITEMS - CALM_ITEMS);
            gappy      = !quiet_tail && ($urandom_range(0, 2) != 0);
            w_word     = random_dimension(48);
            h_word     = random_dimension(12);
            if ($urandom_range(0, 7) == 0) begin
                reprogram_one(($urandom_range(0, 1) != 0) ? rbd_pkg::REG_SRC_HEIGHT
                                                          : rbd_pkg::REG_SRC_WIDTH,
                              ($urandom_range(0, 1) != 0) ? h_word : w_word);
            end else begin
                reprogram(w_word, h_word);
            end
            per_level = sb.pixels_per_level();
            count     = (per_level > 100) ? per_level : per_level * $urandom_range(1, 3);
            if (per_level > 1 && $urandom_range(0, 5) == 0) begin
                count = $urandom_range(1, per_level - 1);
            end
            if (count > RANDOM_ITEMS - random_items) begin
                count = RANDOM_ITEMS - random_items;
            end
            send_pixels(count);
            random_items += count;
        end

        drain();
        if (sb.failures == 0 && sb.expected_texels.size() == 0) begin
            $display("rgba_box_downsample_2x2_tb: PASS");
        end else begin
            $display("rgba_box_downsample_2x2_tb: FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/rbd_pkg.sv
rtl/rbd_pix_if.sv
rtl/rbd_res_if.sv
rtl/rbd_ram.sv
rtl/rbd_front.sv
rtl/rbd_queue.sv
rtl/rbd_back.sv
rtl/rgba_box_downsample_2x2.sv
sim/rgba_box_downsample_2x2_tb.sv
